[hdl/vssm_pkg.sv]
// Shared types and constants for the voice slot sample mixer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package vssm_pkg;

  localparam int Voices    = 8;
  localparam int VoiceIdxW = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int CountW    = $clog2(Voices + 1);
  localparam int SlotW     = 3;
  localparam int PosW      = 24;
  localparam int GainW     = 16;
  localparam int SampleW   = 16;
  localparam int MixW      = 24;
  localparam int ProdW     = SampleW + GainW + 1;
  localparam int ScaledW   = ProdW - 14;
  localparam int SumW      = MixW + 2;
  localparam int QDepthW   = 2;

  localparam logic signed [SumW-1:0] MixMax = SumW'((1 <<< (MixW - 1)) - 1);
  localparam logic signed [SumW-1:0] MixMin = -SumW'(1 <<< (MixW - 1));

  typedef enum logic [1:0] {
    KIND_PLAY   = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_FRAME  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic [SlotW-1:0]          slot;
    logic [PosW-1:0]           wave_length;
    logic [GainW-1:0]          gain;
    logic                      repeat_req;
    logic signed [SampleW-1:0] sample_value;
  } cmd_t;

  typedef struct packed {
    logic [SlotW-1:0]      slot_out;
    logic                  ok;
    logic [PosW-1:0]       next_position;
    logic                  voice_active;
    logic signed [MixW-1:0] mix;
    logic [CountW-1:0]     active_voices;
  } res_t;

endpackage

[hdl/vssm_front.sv]
// Front end: takes input words, decodes the item kind and queues
// commands for the back end. Depends on vssm_pkg.
`timescale 1ns / 1ps
module vssm_front import vssm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [1:0]                kind_i,
  input  logic [SlotW-1:0]          slot_i,
  input  logic [PosW-1:0]           wave_length_i,
  input  logic [GainW-1:0]          gain_i,
  input  logic                      repeat_req_i,
  input  logic signed [SampleW-1:0] sample_value_i,
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o,
  input  logic                      cmd_pop_i
);

  cmd_t               queue_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [QDepthW-1:0] count_q, count_d;
  logic               do_push, do_pop;
  cmd_t               cmd_in;

  assign full_o      = (count_q == QDepthW'(2));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Only fields that the kind uses are kept; the rest are zeroed.
  always_comb begin
    cmd_in              = '0;
    cmd_in.kind         = kind_e'(kind_i);
    case (kind_e'(kind_i))
      KIND_PLAY: begin
        cmd_in.wave_length = wave_length_i;
        cmd_in.gain        = gain_i;
        cmd_in.repeat_req  = repeat_req_i;
      end
      KIND_STOP: begin
        cmd_in.slot = slot_i;
      end
      KIND_SAMPLE: begin
        cmd_in.slot         = slot_i;
        cmd_in.sample_value = sample_value_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[hdl/vssm_back.sv]
// Back end: voice slot state, free slot stack, gain multiply and
// saturating mix, plus the result queue. Depends on vssm_pkg.
`timescale 1ns / 1ps
module vssm_back import vssm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  cmd_pop_o,
  output logic  empty_o,
  output res_t  res_o,
  input  logic  pop_i
);

  logic [PosW-1:0]      voice_len_q    [Voices];
  logic [PosW-1:0]      voice_pos_q    [Voices];
  logic [GainW-1:0]     voice_gain_q   [Voices];
  logic                 voice_repeat_q [Voices];
  logic                 voice_on_q     [Voices];
  logic [VoiceIdxW-1:0] free_stack_q   [Voices];
  logic [CountW-1:0]    free_count_q, free_count_d;
  logic [CountW-1:0]    active_total_q, active_total_d;
  logic signed [MixW-1:0] mix_acc_q, mix_acc_d;

  res_t               out_q [2];
  logic               out_wr_q, out_rd_q;
  logic [QDepthW-1:0] out_cnt_q, out_cnt_d;
  logic               out_pop;

  logic                  go, in_range, hit, in_wave, at_end;
  logic [VoiceIdxW-1:0]  idx, top_idx;
  logic [CountW-1:0]     count_m1;
  logic [PosW-1:0]       pos_cur, len_cur, pos_new;
  logic                  play_ok, stop_ok, smp_ok, free_it, wrap, add_it, frame, addr_kind;
  logic signed [ProdW-1:0]   prod;
  logic signed [ScaledW-1:0] scaled;
  logic signed [SumW-1:0]    sum, sum_sat;
  res_t                  res;

  assign go        = cmd_valid_i && (out_cnt_q != QDepthW'(2));
  assign cmd_pop_o = go;
  assign out_pop   = pop_i && !empty_o;
  assign empty_o   = (out_cnt_q == '0);
  assign res_o     = out_q[out_rd_q];

  assign idx      = cmd_i.slot[VoiceIdxW-1:0];
  assign in_range = (32'(cmd_i.slot) < 32'(Voices));
  assign hit      = in_range && voice_on_q[idx];
  assign count_m1 = free_count_q - 1'b1;
  assign top_idx  = count_m1[VoiceIdxW-1:0];

  assign pos_cur = voice_pos_q[idx];
  assign len_cur = voice_len_q[idx];
  assign in_wave = pos_cur < len_cur;
  assign pos_new = in_wave ? pos_cur + 1'b1 : pos_cur;
  assign at_end  = pos_new >= len_cur;

  // Q2.14 scale, round half up: floor((p + 8192) / 16384).
  assign prod   = ProdW'(cmd_i.sample_value) * $signed({1'b0, voice_gain_q[idx]});
  assign scaled = ScaledW'((prod + ProdW'(8192)) >>> 14);
  assign sum    = SumW'(mix_acc_q) + SumW'(scaled);
  assign sum_sat = (sum > MixMax) ? MixMax : ((sum < MixMin) ? MixMin : sum);

  assign addr_kind = (cmd_i.kind == KIND_STOP) || (cmd_i.kind == KIND_SAMPLE);
  assign play_ok   = (cmd_i.kind == KIND_PLAY) && (free_count_q != '0);
  assign stop_ok   = (cmd_i.kind == KIND_STOP) && hit;
  assign smp_ok    = (cmd_i.kind == KIND_SAMPLE) && hit;
  assign free_it   = stop_ok || (smp_ok && at_end && !voice_repeat_q[idx]);
  assign wrap      = smp_ok && at_end && voice_repeat_q[idx];
  assign add_it    = smp_ok && in_wave;
  assign frame     = (cmd_i.kind == KIND_FRAME);

  always_comb begin
    active_total_d = active_total_q;
    free_count_d   = free_count_q;
    if (play_ok) begin
      active_total_d = active_total_q + 1'b1;
      free_count_d   = count_m1;
    end else if (free_it) begin
      if (active_total_q != '0) begin
        active_total_d = active_total_q - 1'b1;
      end
      if (32'(free_count_q) < 32'(Voices)) begin
        free_count_d = free_count_q + 1'b1;
      end
    end
    mix_acc_d = mix_acc_q;
    if (frame) begin
      mix_acc_d = '0;
    end else if (add_it) begin
      mix_acc_d = MixW'(sum_sat);
    end
  end

  always_comb begin
    res               = '0;
    res.ok            = play_ok || stop_ok || smp_ok || frame;
    res.active_voices = active_total_d;
    if (play_ok) begin
      res.slot_out     = SlotW'(free_stack_q[top_idx]);
      res.voice_active = 1'b1;
    end else if (addr_kind) begin
      res.slot_out = cmd_i.slot;
      if (in_range) begin
        if (free_it || wrap) begin
          res.next_position = '0;
        end else if (smp_ok) begin
          res.next_position = pos_new;
        end else begin
          res.next_position = pos_cur;
        end
        res.voice_active = hit && !free_it;
      end
    end else if (frame) begin
      res.mix = mix_acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Voices; i++) begin
        voice_len_q[i]    <= '0;
        voice_pos_q[i]    <= '0;
        voice_gain_q[i]   <= '0;
        voice_repeat_q[i] <= 1'b0;
        voice_on_q[i]     <= 1'b0;
        free_stack_q[i]   <= VoiceIdxW'(Voices - 1 - i);
      end
      free_count_q   <= CountW'(Voices);
      active_total_q <= '0;
      mix_acc_q      <= '0;
    end else if (go) begin
      free_count_q   <= free_count_d;
      active_total_q <= active_total_d;
      mix_acc_q      <= mix_acc_d;
      if (play_ok) begin
        voice_len_q[free_stack_q[top_idx]]    <= cmd_i.wave_length;
        voice_pos_q[free_stack_q[top_idx]]    <= '0;
        voice_gain_q[free_stack_q[top_idx]]   <= cmd_i.gain;
        voice_repeat_q[free_stack_q[top_idx]] <= cmd_i.repeat_req;
        voice_on_q[free_stack_q[top_idx]]     <= 1'b1;
      end else if (free_it) begin
        // Return the slot to the stack and zero its entries.
        if (32'(free_count_q) < 32'(Voices)) begin
          free_stack_q[free_count_q[VoiceIdxW-1:0]] <= idx;
        end
        voice_len_q[idx]    <= '0;
        voice_pos_q[idx]    <= '0;
        voice_gain_q[idx]   <= '0;
        voice_repeat_q[idx] <= 1'b0;
        voice_on_q[idx]     <= 1'b0;
      end else if (smp_ok) begin
        voice_pos_q[idx] <= wrap ? '0 : pos_new;
      end
    end
  end

  // Result queue
  always_comb begin
    out_cnt_d = out_cnt_q;
    if (go && !out_pop) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (out_pop && !go) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      if (go) begin
        out_wr_q <= ~out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= ~out_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q[out_wr_q] <= res;
    end
  end

endmodule

[hdl/voice_slot_sample_mixer.sv]
// Voice slot sample mixer top level: front end decoder/queue feeding the
// back end. Depends on vssm_pkg, vssm_front and vssm_back.
//
// Usage: items enter as queue words: push with full low accepts one.
// Kinds: play takes a free slot, stop frees a slot, sample mixes one
// voice sample scaled by the voice gain, frame end returns the mix and
// clears it. Every item yields exactly one result word, read as from a
// queue: while empty is low the oldest result is on the result ports,
// and pop takes it.
// Path: an accepted item is registered in the command queue, the back end
// executes it at the queue head and stores the result in the result queue.
// Throughput: one item per cycle unless the result queue is full, set by
// the back end's single step: one voice update, one multiply-accumulate.
// When the receiver stalls, two results wait in the result queue and two
// commands in the command queue, then full rises; nothing is lost.
// Reset: all voices inactive, every slot on the free stack (slot 0 on
// top), mix zero, both queues empty.
`timescale 1ns / 1ps
module voice_slot_sample_mixer import vssm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                kind_i,
  input  logic [SlotW-1:0]          slot_i,
  input  logic [PosW-1:0]           wave_length_i,
  input  logic [GainW-1:0]          gain_i,
  input  logic                      repeat_req_i,
  input  logic signed [SampleW-1:0] sample_value_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [SlotW-1:0]          slot_out_o,
  output logic                      ok_o,
  output logic [PosW-1:0]           next_position_o,
  output logic                      voice_active_o,
  output logic signed [MixW-1:0]    mix_o,
  output logic [CountW-1:0]         active_voices_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  vssm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .kind_i         (kind_i),
    .slot_i         (slot_i),
    .wave_length_i  (wave_length_i),
    .gain_i         (gain_i),
    .repeat_req_i   (repeat_req_i),
    .sample_value_i (sample_value_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  vssm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .res_o       (res),
    .pop_i       (pop)
  );

  assign slot_out_o      = res.slot_out;
  assign ok_o            = res.ok;
  assign next_position_o = res.next_position;
  assign voice_active_o  = res.voice_active;
  assign mix_o           = res.mix;
  assign active_voices_o = res.active_voices;

endmodule

[bench/vssm_checker.sv]
// Checker for the voice slot sample mixer: predicts each result word and compares it.
// Watches both queue handshakes of the block. Depends on vssm_pkg.
`timescale 1ns / 1ps
module vssm_checker import vssm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic [1:0]                kind_i,
  input  logic [SlotW-1:0]          slot_i,
  input  logic [PosW-1:0]           wave_length_i,
  input  logic [GainW-1:0]          gain_i,
  input  logic                      repeat_req_i,
  input  logic signed [SampleW-1:0] sample_value_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  logic [SlotW-1:0]          slot_out_i,
  input  logic                      ok_i,
  input  logic [PosW-1:0]           next_position_i,
  input  logic                      voice_active_i,
  input  logic signed [MixW-1:0]    mix_i,
  input  logic [CountW-1:0]         active_voices_i,
  output int                        err_cnt_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        clips_o,
  output logic [Voices-1:0]         live_o
);

  localparam longint MixTop    = (64'sd1 <<< (MixW - 1)) - 1;
  localparam longint MixBottom = -(64'sd1 <<< (MixW - 1));

  logic [PosW-1:0]      v_len      [Voices];
  logic [PosW-1:0]      v_pos      [Voices];
  logic [GainW-1:0]     v_gain     [Voices];
  logic                 v_rep      [Voices];
  logic                 v_on       [Voices];
  logic [VoiceIdxW-1:0] free_stack [Voices];
  int                   free_cnt;
  int                   live_cnt;
  longint               mix_acc;

  res_t results_due[$];
  res_t got, want, pred;
  cmd_t word;
  logic [Voices-1:0] live_mask;
  int err_cnt = 0;
  int checked = 0;
  int clips = 0;

  assign err_cnt_o = err_cnt;
  assign checked_o = checked;
  assign clips_o   = clips;

  task automatic note_mismatch(input string what, input longint got_v, input longint want_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    err_cnt++;
  endtask

  task automatic release_voice(input int s);
    if (free_cnt < Voices) begin
      free_stack[free_cnt] = VoiceIdxW'(s);
      free_cnt++;
    end
    if (live_cnt > 0) begin
      live_cnt--;
    end
    v_len[s]  = '0;
    v_pos[s]  = '0;
    v_gain[s] = '0;
    v_rep[s]  = 1'b0;
    v_on[s]   = 1'b0;
  endtask

  // Apply one word to the voice state and build the result it yields.
  task automatic predict_word(input cmd_t w, output res_t r);
    int s;
    longint prod;
    longint sum;
    r = '0;
    case (w.kind)
      KIND_PLAY: begin
        if (free_cnt > 0) begin
          free_cnt--;
          s = int'(free_stack[free_cnt]);
          v_len[s]       = w.wave_length;
          v_pos[s]       = '0;
          v_gain[s]      = w.gain;
          v_rep[s]       = w.repeat_req;
          v_on[s]        = 1'b1;
          live_cnt++;
          r.slot_out     = SlotW'(s);
          r.ok           = 1'b1;
          r.voice_active = 1'b1;
        end
      end
      KIND_STOP, KIND_SAMPLE: begin
        s = int'(w.slot);
        r.slot_out = w.slot;
        if (v_on[s]) begin
          r.ok = 1'b1;
          if (w.kind == KIND_STOP) begin
            release_voice(s);
          end else begin
            // zero-length voice: skip the mix, go straight to end-of-wave
            if (v_pos[s] < v_len[s]) begin
              prod = longint'(w.sample_value) * longint'(v_gain[s]);
              sum  = mix_acc + ((prod + 64'sd8192) >>> 14);
              if (sum > MixTop) begin
                sum = MixTop;
                clips++;
              end else if (sum < MixBottom) begin
                sum = MixBottom;
                clips++;
              end
              mix_acc  = sum;
              v_pos[s] = v_pos[s] + 1'b1;
            end
            if (v_pos[s] >= v_len[s]) begin
              if (v_rep[s]) begin
                v_pos[s] = '0;
              end else begin
                release_voice(s);
              end
            end
          end
        end
        r.next_position = v_pos[s];
        r.voice_active  = v_on[s];
      end
      default: begin
        r.mix   = MixW'(mix_acc);
        mix_acc = 0;
        r.ok    = 1'b1;
      end
    endcase
    r.active_voices = CountW'(live_cnt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Voices; i++) begin
        v_len[i]      = '0;
        v_pos[i]      = '0;
        v_gain[i]     = '0;
        v_rep[i]      = 1'b0;
        v_on[i]       = 1'b0;
        free_stack[i] = VoiceIdxW'(Voices - 1 - i);
      end
      free_cnt = Voices;
      live_cnt = 0;
      mix_acc  = 0;
      results_due.delete();
      pending_o <= 0;
      live_o    <= '0;
    end else begin
      // retire first, so a word never matches a prediction made this same edge
      if (pop_i && !empty_i) begin
        got.slot_out      = slot_out_i;
        got.ok            = ok_i;
        got.next_position = next_position_i;
        got.voice_active  = voice_active_i;
        got.mix           = mix_i;
        got.active_voices = active_voices_i;
        if (results_due.size() == 0) begin
          note_mismatch("result word with no prediction waiting", longint'(1), longint'(0));
        end else begin
          want = results_due.pop_front();
          checked++;
          if (got.slot_out !== want.slot_out)
            note_mismatch("slot_out", longint'(got.slot_out), longint'(want.slot_out));
          if (got.ok !== want.ok)
            note_mismatch("ok", longint'(got.ok), longint'(want.ok));
          if (got.next_position !== want.next_position)
            note_mismatch("next_position", longint'(got.next_position),
                          longint'(want.next_position));
          if (got.voice_active !== want.voice_active)
            note_mismatch("voice_active", longint'(got.voice_active),
                          longint'(want.voice_active));
          if (got.mix !== want.mix)
            note_mismatch("mix", longint'(got.mix), longint'(want.mix));
          if (got.active_voices !== want.active_voices)
            note_mismatch("active_voices", longint'(got.active_voices),
                          longint'(want.active_voices));
        end
      end
      if (push_i && !full_i) begin
        word.kind         = kind_e'(kind_i);
        word.slot         = slot_i;
        word.wave_length  = wave_length_i;
        word.gain         = gain_i;
        word.repeat_req   = repeat_req_i;
        word.sample_value = sample_value_i;
        predict_word(word, pred);
        results_due.push_back(pred);
      end
      for (int i = 0; i < Voices; i++) begin
        live_mask[i] = v_on[i];
      end
      pending_o <= results_due.size();
      live_o    <= live_mask;
    end
  end

endmodule

[bench/tb_voice_slot_sample_mixer.sv]
// Testbench top for the voice slot sample mixer: clock, reset, stimulus and verdict.
// Depends on vssm_pkg, voice_slot_sample_mixer and vssm_checker.
`timescale 1ns / 1ps
module tb_voice_slot_sample_mixer;
  import vssm_pkg::*;

  localparam int HoldCycles  = 150;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;

  typedef enum int {
    STIM_NORMAL,
    STIM_LOUD_POS,
    STIM_LOUD_NEG
  } stim_e;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      push;
  logic                      full;
  logic [1:0]                kind_i;
  logic [SlotW-1:0]          slot_i;
  logic [PosW-1:0]           wave_length_i;
  logic [GainW-1:0]          gain_i;
  logic                      repeat_req_i;
  logic signed [SampleW-1:0] sample_value_i;
  logic                      empty;
  logic                      pop;
  logic [SlotW-1:0]          slot_out_o;
  logic                      ok_o;
  logic [PosW-1:0]           next_position_o;
  logic                      voice_active_o;
  logic signed [MixW-1:0]    mix_o;
  logic [CountW-1:0]         active_voices_o;

  int                err_cnt;
  int                pending;
  int                checked;
  int                clips;
  logic [Voices-1:0] live;

  int words_sent = 0;
  int cycle_cnt  = 0;
  bit tx_burst   = 1'b0;
  bit rx_burst   = 1'b0;
  bit hold_req   = 1'b0;

  voice_slot_sample_mixer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .slot_i         (slot_i),
    .wave_length_i  (wave_length_i),
    .gain_i         (gain_i),
    .repeat_req_i   (repeat_req_i),
    .sample_value_i (sample_value_i),
    .empty          (empty),
    .pop            (pop),
    .slot_out_o     (slot_out_o),
    .ok_o           (ok_o),
    .next_position_o(next_position_o),
    .voice_active_o (voice_active_o),
    .mix_o          (mix_o),
    .active_voices_o(active_voices_o)
  );

  vssm_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .kind_i         (kind_i),
    .slot_i         (slot_i),
    .wave_length_i  (wave_length_i),
    .gain_i         (gain_i),
    .repeat_req_i   (repeat_req_i),
    .sample_value_i (sample_value_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .slot_out_i     (slot_out_o),
    .ok_i           (ok_o),
    .next_position_i(next_position_o),
    .voice_active_i (voice_active_o),
    .mix_i          (mix_o),
    .active_voices_i(active_voices_o),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending),
    .checked_o      (checked),
    .clips_o        (clips),
    .live_o         (live)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
      $display("tb_voice_slot_sample_mixer NOT OK");
      $finish;
    end
  end

  function automatic cmd_t mk(kind_e k, int sl, int len, int g, bit rep, int sv);
    cmd_t w;
    w.kind         = k;
    w.slot         = SlotW'(sl);
    w.wave_length  = PosW'(len);
    w.gain         = GainW'(g);
    w.repeat_req   = rep;
    w.sample_value = SampleW'(sv);
    return w;
  endfunction

  // Mostly well-formed traffic aimed at live voices, with some raw noise.
  function automatic cmd_t draw_word(stim_e mode, logic [Voices-1:0] live_now);
    cmd_t w;
    int   r;
    int   v;
    int   idx[$];
    w.kind         = kind_e'($urandom_range(0, 3));
    w.slot         = SlotW'($urandom_range(0, Voices - 1));
    w.wave_length  = PosW'($urandom);
    w.gain         = GainW'($urandom);
    w.repeat_req   = 1'($urandom);
    w.sample_value = SampleW'($urandom);
    if ($urandom_range(0, 99) < 10) begin
      return w;
    end
    r = $urandom_range(0, 99);
    if (mode == STIM_NORMAL) begin
      w.kind = (r < 20) ? KIND_PLAY : (r < 30) ? KIND_STOP : (r < 85) ? KIND_SAMPLE : KIND_FRAME;
    end else begin
      w.kind = (r < 15) ? KIND_PLAY : (r < 17) ? KIND_STOP : (r < 99) ? KIND_SAMPLE : KIND_FRAME;
    end
    for (int i = 0; i < Voices; i++) begin
      if (live_now[i]) idx.push_back(i);
    end
    if (idx.size() > 0 && $urandom_range(0, 9) < 8) begin
      w.slot = SlotW'(idx[$urandom_range(0, idx.size() - 1)]);
    end
    if (mode == STIM_NORMAL) begin
      if ($urandom_range(0, 9) < 8) w.wave_length = PosW'($urandom_range(0, 12));
    end else begin
      // long looping voices at high gain drive the mix into the rails
      w.wave_length = PosW'($urandom_range(16, 64));
      w.repeat_req  = 1'b1;
      w.gain        = GainW'($urandom_range(16'hC000, 16'hFFFF));
      v = $urandom_range(30000, 32767);
      if (mode == STIM_LOUD_NEG) v = -v - 1;
      w.sample_value = SampleW'(v);
    end
    return w;
  endfunction

  task automatic send_word(input cmd_t w);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    kind_i         <= w.kind;
    slot_i         <= w.slot;
    wave_length_i  <= w.wave_length;
    gain_i         <= w.gain;
    repeat_req_i   <= w.repeat_req;
    sample_value_i <= w.sample_value;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic run_random(input stim_e mode, input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      send_word(draw_word(mode, live));
    end
  endtask

  // Drop push and hold until every predicted word has come back.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    push           <= 1'b0;
    kind_i         <= KIND_PLAY;
    slot_i         <= '0;
    wave_length_i  <= '0;
    gain_i         <= '0;
    repeat_req_i   <= 1'b0;
    sample_value_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle mix, dead slots, fill every slot, overflow, end-of-wave cases
    send_word(mk(KIND_FRAME,  0, 0, 0, 0, 0));
    send_word(mk(KIND_STOP,   0, 0, 0, 0, 0));
    send_word(mk(KIND_SAMPLE, 7, 0, 0, 0, 32767));
    send_word(mk(KIND_PLAY,   0, 1, 16'hFFFF, 0, 0));
    send_word(mk(KIND_PLAY,   0, 24'hFFFFFF, 16'h4000, 1, 0));
    send_word(mk(KIND_PLAY,   0, 0, 0, 0, 0));
    send_word(mk(KIND_PLAY,   0, 0, 16'h1234, 1, 0));
    send_word(mk(KIND_PLAY,   0, 2, 16'hFFFF, 1, 0));
    send_word(mk(KIND_PLAY,   0, 3, 16'h2000, 0, 0));
    send_word(mk(KIND_PLAY,   0, 5, 16'h4000, 0, 0));
    send_word(mk(KIND_PLAY,   0, 4, 16'hFFFF, 0, 0));
    send_word(mk(KIND_PLAY,   0, 7, 16'h4000, 1, 0));
    send_word(mk(KIND_SAMPLE, 0, 0, 0, 0, 32767));
    send_word(mk(KIND_SAMPLE, 1, 0, 0, 0, -32768));
    send_word(mk(KIND_SAMPLE, 2, 0, 0, 0, 12345));
    send_word(mk(KIND_SAMPLE, 3, 0, 0, 0, -1));
    // half-way products: +0.5 rounds up, -0.5 rounds toward zero
    send_word(mk(KIND_SAMPLE, 5, 0, 0, 0, 1));
    send_word(mk(KIND_SAMPLE, 5, 0, 0, 0, -1));
    send_word(mk(KIND_SAMPLE, 5, 0, 0, 0, 3));
    send_word(mk(KIND_SAMPLE, 4, 0, 0, 0, -32768));
    send_word(mk(KIND_SAMPLE, 4, 0, 0, 0, -32768));
    send_word(mk(KIND_STOP,   6, 0, 0, 0, 0));
    send_word(mk(KIND_STOP,   6, 0, 0, 0, 0));
    send_word(mk(KIND_SAMPLE, 0, 0, 0, 0, 100));
    send_word(mk(KIND_FRAME,  0, 0, 0, 0, 0));

    run_random(STIM_NORMAL, 200);

    // back-pressure: result side holds off while words keep coming
    rx_burst = 1'b0;
    tx_burst = 1'b1;
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_word(draw_word(STIM_NORMAL, live));
    end
    wait_drained();

    run_random(STIM_LOUD_POS, 120);
    send_word(mk(KIND_FRAME, 0, 0, 0, 0, 0));
    run_random(STIM_LOUD_NEG, 120);
    send_word(mk(KIND_FRAME, 0, 0, 0, 0, 0));
    run_random(STIM_NORMAL, 170);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words of every kind incl. slot overflow and zero-length voices;",
             words_sent);
    $display("checked %0d results, %0d of them after a clipped mix update.", checked, clips);
    if (err_cnt == 0) begin
      $display("tb_voice_slot_sample_mixer OK");
    end else begin
      $display("tb_voice_slot_sample_mixer NOT OK");
    end
    $finish;
  end

endmodule

[voice_slot_sample_mixer.f]
hdl/vssm_pkg.sv
hdl/vssm_front.sv
hdl/vssm_back.sv
hdl/voice_slot_sample_mixer.sv
bench/vssm_checker.sv
bench/tb_voice_slot_sample_mixer.sv
